[sv/dcws_pkg.sv]
// Shared constants, payload types and queue entry type for the delay correlator.
// Used by every module of delay_correlate_window_sum_core; depends on nothing.
package dcws_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_DELAY = 1024;	// power of two: pointers wrap by overflow
	localparam int HIST_AW = $clog2(MAX_DELAY);
	localparam int MAX_WINDOW = 256;	// power of two as well
	localparam int WIN_AW = $clog2(MAX_WINDOW);

	localparam int DELAY_BITS = 11;
	localparam int WINDOW_BITS = 9;
	localparam int TOTAL_BITS = 40;

	localparam int PROD_BITS = 2 * SAMPLE_BITS + 1;
	localparam int MAG_BITS = 2 * SAMPLE_BITS;
	localparam int RAD_BITS = 2 * MAG_BITS;
	localparam int REM_BITS = MAG_BITS + 2;
	localparam int ITER_BITS = $clog2(MAG_BITS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LENGTH = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 4'd1;

	localparam logic [DELAY_BITS-1:0] DELAY_RESET = 11'd64;
	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 9'd16;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_re;
		logic signed [SAMPLE_BITS-1:0] sample_im;
		logic                          block_last;
	} sample_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] correlation_sum;
		logic                  end_of_block;
	} result_t;

	// front to back: |x|^2 + |y|^2 of the delayed product, plus end-of-block flag
	typedef struct packed {
		logic [RAD_BITS-1:0] radicand;
		logic                last;
	} work_t;

endpackage

[sv/delay_correlate_window_sum_core.sv]
// Delay correlator with moving-window sum. Each sample is multiplied by the conjugate of
// the sample delay_length earlier, the product's magnitude is the floor square root of
// re^2 + im^2, and the result is the sum of the last window_length magnitudes. One
// result per sample, in order. The front end reads the history, forms the product and the
// squares and pushes to the queue; the back end runs the bit-serial square root (one root
// bit per cycle, 32 bits), which limits the sustained rate: it takes no new item until the
// last result is in the output register. A two-entry queue lets the front end run
// ahead of the back end. No clearing pass after reset: fill flags stand in for the
// cleared stores. Register writes are taken every cycle and belong to idle periods.
// Depends on dcws_pkg, dcws_front, dcws_queue, dcws_back.
module delay_correlate_window_sum_core import dcws_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      sample_valid,
	output logic                      sample_ready,
	input  sample_t                   sample,
	output logic                      result_valid,
	input  logic                      result_ready,
	output result_t                   result
);

	logic [DELAY_BITS-1:0] delay_q;
	logic [WINDOW_BITS-1:0] window_q;
	logic [DELAY_BITS-1:0] delay_eff;
	logic [WINDOW_BITS-1:0] window_eff;
	logic [HIST_AW-1:0] delay_lag;
	logic [WIN_AW-1:0] window_lag;
	logic push_valid, push_ready, pop_valid, pop_ready;
	work_t push_data, pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DELAY_LENGTH: begin
					delay_q <= cfg_data[DELAY_BITS-1:0];
				end
				REG_WINDOW_LENGTH: begin
					window_q <= cfg_data[WINDOW_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// saturate to 1..MAX; the full length wraps to lag 0, i.e. the slot being replaced
	assign delay_eff = (delay_q == '0) ? DELAY_BITS'(1) :
		(delay_q > DELAY_BITS'(MAX_DELAY)) ? DELAY_BITS'(MAX_DELAY) : delay_q;
	assign window_eff = (window_q == '0) ? WINDOW_BITS'(1) :
		(window_q > WINDOW_BITS'(MAX_WINDOW)) ? WINDOW_BITS'(MAX_WINDOW) : window_q;
	assign delay_lag = delay_eff[HIST_AW-1:0];
	assign window_lag = window_eff[WIN_AW-1:0];

	dcws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.delay_lag    (delay_lag),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	dcws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dcws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_lag   (window_lag),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[sv/dcws_front.sv]
// Front end: sample history memory, conjugate product and squared magnitude.
// Pushes one work_t per accepted sample; depends on dcws_pkg.
module dcws_front import dcws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [HIST_AW-1:0] delay_lag,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  sample_t            sample,
	output logic               push_valid,
	input  logic               push_ready,
	output work_t              push_data
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_SQ   = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;
	localparam logic [HIST_AW-1:0] PTR_LAST = HIST_AW'(MAX_DELAY - 1);

	logic [1:0] state_q;
	logic [2*SAMPLE_BITS-1:0] hist_mem [MAX_DELAY];
	logic [2*SAMPLE_BITS-1:0] hist_rd_q;
	logic [HIST_AW-1:0] wr_ptr_q;
	logic [HIST_AW-1:0] rd_addr;
	logic hist_full_q;
	logic hit_q;
	logic last_q;
	logic accept;
	logic signed [SAMPLE_BITS-1:0] a_q, b_q, c, e;
	logic signed [2*SAMPLE_BITS-1:0] p_ac, p_be, p_bc, p_ae;
	logic [PROD_BITS-1:0] pre_s, pim_s, pre_q, pim_q;
	logic [MAG_BITS-1:0] abs_re, abs_im;
	logic [RAD_BITS-1:0] sq_re, sq_im, sq_re_q, sq_im_q;

	assign sample_ready = (state_q == F_IDLE);
	assign accept = sample_valid && sample_ready;
	assign rd_addr = wr_ptr_q - delay_lag;

	// read-first: a lag of MAX_DELAY reads the slot before it is overwritten
	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[wr_ptr_q] <= {sample.sample_re, sample.sample_im};
			hist_rd_q <= hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wr_ptr_q <= '0;
			hist_full_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_MUL;
						wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
						if (wr_ptr_q == PTR_LAST) begin
							hist_full_q <= 1'b1;
						end
					end
				end
				F_MUL: begin
					state_q <= F_SQ;
				end
				F_SQ: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// never-written slots read as the reset zeros
	assign c = hit_q ? hist_rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
	assign e = hit_q ? hist_rd_q[SAMPLE_BITS-1:0] : '0;

	// (a + jb) * conj(c + je) = (ac + be) + j(bc - ae)
	assign p_ac = a_q * c;
	assign p_be = b_q * e;
	assign p_bc = b_q * c;
	assign p_ae = a_q * e;
	assign pre_s = {p_ac[2*SAMPLE_BITS-1], p_ac} + {p_be[2*SAMPLE_BITS-1], p_be};
	assign pim_s = {p_bc[2*SAMPLE_BITS-1], p_bc} - {p_ae[2*SAMPLE_BITS-1], p_ae};

	assign abs_re = pre_q[PROD_BITS-1] ? MAG_BITS'(~pre_q + PROD_BITS'(1)) : pre_q[MAG_BITS-1:0];
	assign abs_im = pim_q[PROD_BITS-1] ? MAG_BITS'(~pim_q + PROD_BITS'(1)) : pim_q[MAG_BITS-1:0];
	assign sq_re = abs_re * abs_re;
	assign sq_im = abs_im * abs_im;

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= sample.sample_re;
			b_q <= sample.sample_im;
			last_q <= sample.block_last;
			hit_q <= hist_full_q || (rd_addr < wr_ptr_q);
		end
		if (state_q == F_MUL) begin
			pre_q <= pre_s;
			pim_q <= pim_s;
		end
		if (state_q == F_SQ) begin
			sq_re_q <= sq_re;
			sq_im_q <= sq_im;
		end
	end

	assign push_valid = (state_q == F_PUSH);
	assign push_data.radicand = sq_re_q + sq_im_q;
	assign push_data.last = last_q;

endmodule

[sv/dcws_queue.sv]
// Two-entry queue of work_t between the front end and the back end.
// Depends on dcws_pkg.
module dcws_queue import dcws_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	work_t entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic push_fire;
	logic pop_fire;

	assign push_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/dcws_back.sv]
// Back end: bit-serial integer square root, magnitude window memory, running total
// and the output register. Depends on dcws_pkg.
module dcws_back import dcws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WIN_AW-1:0] window_lag,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  work_t             pop_data,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_ITER = 2'd1;
	localparam logic [1:0] B_DONE = 2'd2;
	localparam logic [WIN_AW-1:0] WP_LAST = WIN_AW'(MAX_WINDOW - 1);
	localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(MAG_BITS - 1);

	logic [1:0] state_q;
	logic [ITER_BITS-1:0] iter_q;
	logic [RAD_BITS-1:0] rad_q;
	logic [REM_BITS-1:0] rem_q;
	logic [MAG_BITS-1:0] root_q;
	logic last_q;
	logic [MAG_BITS-1:0] win_mem [MAX_WINDOW];
	logic [MAG_BITS-1:0] old_q;
	logic old_hit_q;
	logic [WIN_AW-1:0] wp_q;
	logic [WIN_AW-1:0] old_addr;
	logic win_full_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [TOTAL_BITS-1:0] total_next;
	logic [MAG_BITS-1:0] old_mag;
	logic [REM_BITS+1:0] cand;
	logic [REM_BITS+1:0] trial;
	logic take;
	logic pop_fire;
	logic out_load;
	logic out_valid_q;
	result_t out_q;

	assign pop_ready = (state_q == B_IDLE);
	assign pop_fire = pop_valid && pop_ready;
	assign old_addr = wp_q - window_lag;

	// one root bit per cycle, two radicand bits brought down each time
	assign cand = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign take = (cand >= trial);

	assign old_mag = old_hit_q ? old_q : '0;
	assign total_next = total_q + TOTAL_BITS'(root_q) - TOTAL_BITS'(old_mag);
	assign out_load = (state_q == B_DONE) && (!out_valid_q || result_ready);

	// read-first: a full-size window reads the slot about to be replaced
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			old_q <= win_mem[old_addr];
		end
		if (out_load) begin
			win_mem[wp_q] <= root_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			rad_q <= pop_data.radicand;
			last_q <= pop_data.last;
			rem_q <= '0;
			root_q <= '0;
			old_hit_q <= win_full_q || (old_addr < wp_q);
		end else if (state_q == B_ITER) begin
			rad_q <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q <= take ? REM_BITS'(cand - trial) : REM_BITS'(cand);
			root_q <= {root_q[MAG_BITS-2:0], take};
		end
		if (out_load) begin
			out_q.correlation_sum <= total_next;
			out_q.end_of_block <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			iter_q <= '0;
			wp_q <= '0;
			win_full_q <= 1'b0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop_fire) begin
						state_q <= B_ITER;
						iter_q <= '0;
					end
				end
				B_ITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_LAST) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase

			if (out_load) begin
				total_q <= total_next;
				wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
				if (wp_q == WP_LAST) begin
					win_full_q <= 1'b1;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

`ifndef SYNTHESIS
	a_iter_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ITER && iter_q == '0) |-> $past(state_q) == B_IDLE)
		else $error("square root started without a pop");

	a_root_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE) |-> (rem_q <= {root_q, 1'b0}))
		else $error("square root remainder exceeds 2*root");

	a_wp_moves_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q) |-> $past(out_load))
		else $error("window pointer moved without a result");
`endif

endmodule

[test/dcws_checker.sv]
// Scoreboard for delay_correlate_window_sum_core: follows register writes, predicts the
// windowed correlation sum of every accepted sample word and checks the result words.
// Depends on dcws_pkg.
module dcws_checker import dcws_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      sample_valid,
	input  logic                      sample_ready,
	input  sample_t                   sample,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  result_t                   result,
	output int                        error_count,
	output int                        in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PEND_DEPTH = 64;

	logic [DELAY_BITS-1:0]         lag_reg;
	logic [WINDOW_BITS-1:0]        span_reg;
	logic signed [SAMPLE_BITS-1:0] past_re [MAX_DELAY];
	logic signed [SAMPLE_BITS-1:0] past_im [MAX_DELAY];
	logic [MAG_BITS-1:0]           recent_mag [MAX_WINDOW];
	int                            hist_ptr;
	int                            win_ptr;
	logic [TOTAL_BITS-1:0]         window_total;
	// ring of predicted words still waiting for their result
	result_t                       pending_sums [PEND_DEPTH];
	int                            pend_head;
	int                            pend_count;
	int                            mismatches;

	function automatic logic [MAG_BITS-1:0] floor_root(bit [63:0] radicand);
		logic [MAG_BITS-1:0] root;
		logic [MAG_BITS-1:0] trial;
		root = '0;
		for (int b = MAG_BITS - 1; b >= 0; b--) begin
			trial = root | (MAG_BITS'(1) << b);
			if (64'(trial) * 64'(trial) <= radicand)
				root = trial;
		end
		return root;
	endfunction

	function automatic result_t next_window_sum(sample_t word);
		result_t sum;
		longint a, b, c, e, prod_re, prod_im;
		bit [63:0] abs_re, abs_im;
		logic [MAG_BITS-1:0] mag;
		int lag, span, rd, leaving;
		// out-of-range lengths saturate into 1..MAX
		lag = int'(lag_reg);
		if (lag < 1) lag = 1;
		if (lag > MAX_DELAY) lag = MAX_DELAY;
		span = int'(span_reg);
		if (span < 1) span = 1;
		if (span > MAX_WINDOW) span = MAX_WINDOW;

		rd = (hist_ptr + MAX_DELAY - lag) % MAX_DELAY;
		a = longint'($signed(word.sample_re));
		b = longint'($signed(word.sample_im));
		c = longint'(past_re[rd]);
		e = longint'(past_im[rd]);
		// new sample times conjugate of the delayed one
		prod_re = a * c + b * e;
		prod_im = b * c - a * e;
		abs_re = (prod_re < 0) ? -prod_re : prod_re;
		abs_im = (prod_im < 0) ? -prod_im : prod_im;
		mag = floor_root(abs_re * abs_re + abs_im * abs_im);

		past_re[hist_ptr] = word.sample_re;
		past_im[hist_ptr] = word.sample_im;
		hist_ptr = (hist_ptr + 1) % MAX_DELAY;

		leaving = (win_ptr + MAX_WINDOW - span) % MAX_WINDOW;
		window_total = window_total + TOTAL_BITS'(mag) - TOTAL_BITS'(recent_mag[leaving]);
		recent_mag[win_ptr] = mag;
		win_ptr = (win_ptr + 1) % MAX_WINDOW;

		sum.correlation_sum = window_total;
		sum.end_of_block = word.block_last;
		return sum;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			for (int i = 0; i < MAX_DELAY; i++) begin
				past_re[i] = '0;
				past_im[i] = '0;
			end
			for (int i = 0; i < MAX_WINDOW; i++)
				recent_mag[i] = '0;
			hist_ptr = 0;
			win_ptr = 0;
			window_total = '0;
			lag_reg = DELAY_RESET;
			span_reg = WINDOW_RESET;
			pend_head = 0;
			pend_count = 0;
			mismatches = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pend_count == 0) begin
					mismatches++;
					$display("%0t unexpected result word: sum %0d, end_of_block %0b",
						$time, result.correlation_sum, result.end_of_block);
				end else begin
					want = pending_sums[pend_head];
					pend_head = (pend_head + 1) % PEND_DEPTH;
					pend_count--;
					if (result.correlation_sum !== want.correlation_sum) begin
						mismatches++;
						$display("%0t correlation_sum: expected %0d, got %0d",
							$time, want.correlation_sum, result.correlation_sum);
					end
					if (result.end_of_block !== want.end_of_block) begin
						mismatches++;
						$display("%0t end_of_block: expected %0b, got %0b",
							$time, want.end_of_block, result.end_of_block);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY_LENGTH: begin
						lag_reg = cfg_data[DELAY_BITS-1:0];
					end
					REG_WINDOW_LENGTH: begin
						span_reg = cfg_data[WINDOW_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (sample_valid && sample_ready) begin
				fresh = next_window_sum(sample);
				if (pend_count == PEND_DEPTH) begin
					mismatches++;
					$display("%0t more than %0d sample words in flight", $time, PEND_DEPTH);
				end else begin
					pending_sums[(pend_head + pend_count) % PEND_DEPTH] = fresh;
					pend_count++;
				end
			end
		end
		error_count <= mismatches;
		in_flight <= pend_count;
	end

endmodule

[test/tb_delay_correlate_window_sum_core.sv]
// Testbench top for delay_correlate_window_sum_core: clock, reset, register programming,
// sample stimulus and output back-pressure; checking is done in dcws_checker.
// Depends on dcws_pkg, dcws_checker and the core.
module tb_delay_correlate_window_sum_core import dcws_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP = 12;
	localparam int LONG_HOLD = 600;
	localparam int TAIL_CYCLES = 80;
	localparam int PHASE_ITEMS = 82;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      sample_valid;
	logic                      sample_ready;
	sample_t                   sample;
	logic                      result_valid;
	logic                      result_ready;
	result_t                   result;
	int                        error_count;
	int                        in_flight;

	bit sender_steady;
	bit sink_steady;
	int stall_requests;
	int stalls_served;
	int samples_sent;
	int settings;

	delay_correlate_window_sum_core DUT (.*);

	dcws_checker scoreboard (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_gap(bit steady);
		return steady ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_part(int kind);
		case (kind)
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			1: return SAMPLE_BITS'($urandom_range(0, 64) - 32);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t word;
		int kind;
		kind = $urandom_range(0, 3);
		word.sample_re = random_part(kind);
		word.sample_im = random_part(kind);
		word.block_last = ($urandom_range(0, 7) == 0);
		return word;
	endfunction

	task automatic put_sample(input sample_t word);
		int gap;
		if ($urandom_range(0, 19) == 0)
			sender_steady = !sender_steady;
		gap = draw_gap(sender_steady);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= word;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		samples_sent++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (in_flight != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_index <= index;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// only called with the pipeline empty; also pokes an unmapped index
	task automatic set_lengths(input logic [CFG_DATA_BITS-1:0] lag,
			input logic [CFG_DATA_BITS-1:0] span);
		wait_drained();
		write_reg(REG_DELAY_LENGTH, lag);
		write_reg(REG_WINDOW_LENGTH, span);
		write_reg(CFG_INDEX_BITS'($urandom_range(REG_WINDOW_LENGTH + 1,
			2 ** CFG_INDEX_BITS - 1)), CFG_DATA_BITS'($urandom));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input int count, input int hold_at);
		for (int k = 0; k < count; k++) begin
			if (k == hold_at)
				stall_requests++;
			put_sample(random_sample());
		end
		sample_valid <= 1'b0;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset lengths: the lag is never reached, so every magnitude is zero
		for (int k = 0; k < 4; k++)
			put_sample(random_sample());
		sample_valid <= 1'b0;

		// zero lag and oversize window saturate to 1 and MAX_WINDOW
		set_lengths(16'd0, 16'd511);
		put_sample(sample_t'{16'sh8000, 16'sh8000, 1'b1});
		put_sample(sample_t'{16'sh8000, 16'sh8000, 1'b0});
		put_sample(sample_t'{16'sh7fff, 16'sh7fff, 1'b0});
		put_sample(sample_t'{16'sh7fff, 16'sh8000, 1'b1});
		put_sample(sample_t'{16'sh8000, 16'sh7fff, 1'b0});
		put_sample(sample_t'{16'sh0000, 16'sh0000, 1'b0});
		put_sample(sample_t'{16'sh0000, 16'sh8000, 1'b1});
		put_sample(sample_t'{16'shffff, 16'shffff, 1'b0});
		put_sample(sample_t'{16'sh0001, 16'sh0000, 1'b0});
		put_sample(sample_t'{16'sh0000, 16'sh0001, 1'b1});
		put_sample(sample_t'{16'sh8000, 16'sh0000, 1'b0});
		put_sample(sample_t'{16'sh7fff, 16'sh0000, 1'b0});
		put_sample(sample_t'{16'sh5555, 16'shaaaa, 1'b1});
		put_sample(sample_t'{16'shaaaa, 16'sh5555, 1'b0});
		sample_valid <= 1'b0;

		// all-ones lag saturates to MAX_DELAY, zero window to 1
		set_lengths(16'd2047, 16'd0);
		put_sample(sample_t'{16'sh7fff, 16'sh8000, 1'b0});
		put_sample(sample_t'{16'sh8000, 16'sh8000, 1'b1});
		put_sample(random_sample());
		put_sample(random_sample());
		sample_valid <= 1'b0;

		// lengths change between phases without reset: stores carry over
		set_lengths(CFG_DATA_BITS'(MAX_DELAY), CFG_DATA_BITS'(MAX_WINDOW));
		run_phase(PHASE_ITEMS, -1);
		set_lengths(16'd1, 16'd1);
		run_phase(PHASE_ITEMS, 10);
		set_lengths(CFG_DATA_BITS'($urandom_range(1, 16)),
			CFG_DATA_BITS'($urandom_range(1, 16)));
		run_phase(PHASE_ITEMS, -1);
		set_lengths(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom));
		run_phase(PHASE_ITEMS, 30);
		set_lengths(CFG_DATA_BITS'($urandom_range(1, 64)), CFG_DATA_BITS'(MAX_WINDOW));
		run_phase(PHASE_ITEMS, -1);
		set_lengths(CFG_DATA_BITS'($urandom_range(1, MAX_DELAY)),
			CFG_DATA_BITS'($urandom_range(1, MAX_WINDOW)));
		run_phase(PHASE_ITEMS, -1);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d samples under %0d length settings (lags 1..%0d, windows 1..%0d),",
			samples_sent, settings + 1, MAX_DELAY, MAX_WINDOW);
		$display("saturated and unmapped register writes, and %0d long output holds.",
			stalls_served);
		if (error_count == 0 && in_flight == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : result_sink
		int gap;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				sink_steady = !sink_steady;
			gap = draw_gap(sink_steady);
			// long hold while the sender keeps pushing: core fills and stalls its input
			if (stalls_served != stall_requests) begin
				stalls_served = stall_requests;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycles, in_flight);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
sv/dcws_pkg.sv
sv/dcws_front.sv
sv/dcws_queue.sv
sv/dcws_back.sv
sv/delay_correlate_window_sum_core.sv
test/dcws_checker.sv
test/tb_delay_correlate_window_sum_core.sv
